// File: hw/rtl/lssd_pkg.sv
// Shared constants and types for the longest subset sum block.
package lssd_pkg;

   localparam int MAX_ITEMS_DEF  = 32;
   localparam int MAX_TARGET_DEF = 1023;
   localparam int VALUE_W        = 10;
   localparam int KIND_W         = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_LENGTH    = 2'd0,
      KIND_ELEMENT   = 2'd1,
      KIND_NOT_FOUND = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_HEAD_RD,
      ST_HEAD,
      ST_WALK_ITEM,
      ST_WALK_RD,
      ST_WALK_CMP
   } state_type;

endpackage

// File: hw/rtl/longest_subset_sum_dp.sv
// Top level of the longest exact-sum subset block: loader, table sequencer and output word.
// Loading takes one input word per cycle while idle (req_stall is high otherwise); a word
// without is_last gives no result. After the last word the final row is initialised, the
// table is filled row by row (two table read ports, one write port), then the walk runs,
// which waits whenever the result side stalls.
// Reset is synchronous and clears control state and the target; RAM contents are not cleared.
module longest_subset_sum_dp #(
   parameter int MAX_ITEMS  = lssd_pkg::MAX_ITEMS_DEF,
   parameter int MAX_TARGET = lssd_pkg::MAX_TARGET_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lssd_pkg::VALUE_W-1:0] req_item_value,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lssd_pkg::KIND_W-1:0]  rsp_kind,
   output logic [lssd_pkg::VALUE_W-1:0] rsp_value,
   output logic                         rsp_run_end,
   input  logic                         csr_write_en,
   input  logic [lssd_pkg::VALUE_W-1:0] csr_write_data
);
   import lssd_pkg::*;

   localparam int RW        = $clog2(MAX_ITEMS + 1);
   localparam int IW        = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SW        = $clog2(MAX_TARGET + 1);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 2);
   localparam int SUM_W     = ((SW > VALUE_W) ? SW : VALUE_W) + 1;
   localparam int TBL_AW    = RW + SW;
   localparam int TBL_DEPTH = (MAX_ITEMS + 1) * (2 ** SW);
   localparam logic [CNT_W-1:0] IMP = '1;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] target_ff;
   logic [RW-1:0]      count_ff, count_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [SW-1:0]      col_ff, col_in;
   logic [CNT_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0]   len_ff, len_in;

   logic               rsp_valid_ff;
   kind_type           rsp_kind_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic               rsp_end_ff;

   logic               accept;
   logic               item_we;
   logic [VALUE_W-1:0] item_a;
   logic [SW-1:0]      t_sat;
   logic [RW-1:0]      row_next;
   logic [SUM_W-1:0]   sum_col;
   logic               head_rd;
   logic               last_col;
   logic               out_free;

   logic               tbl_we;
   logic [TBL_AW-1:0]  tbl_waddr;
   logic [CNT_W-1:0]   tbl_wdata;
   logic [TBL_AW-1:0]  tbl_raddr_a;
   logic [TBL_AW-1:0]  tbl_raddr_b;
   logic [CNT_W-1:0]   rd_skip;
   logic [CNT_W-1:0]   rd_take;
   logic [CNT_W-1:0]   best;
   logic               choose;

   logic               emit;
   kind_type           emit_kind;
   logic [VALUE_W-1:0] emit_value;
   logic               emit_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign item_we   = accept && (int'(count_ff) < MAX_ITEMS);

   // Targets beyond MAX_TARGET are clipped to column MAX_TARGET.
   assign t_sat = (int'(target_ff) > MAX_TARGET) ? SW'(MAX_TARGET) : SW'(target_ff);

   assign row_next = row_ff + RW'(1);
   assign sum_col  = SUM_W'(col_ff) + SUM_W'(item_a);
   assign head_rd  = (state_ff == ST_HEAD_RD) || (state_ff == ST_HEAD);
   assign last_col = (col_ff == t_sat);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Both reads look at the row below (the skip read looks at row 0 in the head states);
   // the take read may point past the target, in which case the compare unit ignores it.
   assign tbl_raddr_a = head_rd ? '0 : {row_next, col_ff};
   assign tbl_raddr_b = {row_next, sum_col[SW-1:0]};

   lssd_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MAX_ITEMS)
   ) u_item_ram (
      .clock   (clock),
      .we      (item_we),
      .waddr   (count_ff[IW-1:0]),
      .wdata   (req_item_value),
      .raddr_a (row_ff[IW-1:0]),
      .rdata_a (item_a),
      .raddr_b (row_ff[IW-1:0]),
      .rdata_b ()
   );

   lssd_ram #(
      .WIDTH (CNT_W),
      .DEPTH (TBL_DEPTH)
   ) u_table_ram (
      .clock   (clock),
      .we      (tbl_we),
      .waddr   (tbl_waddr),
      .wdata   (tbl_wdata),
      .raddr_a (tbl_raddr_a),
      .rdata_a (rd_skip),
      .raddr_b (tbl_raddr_b),
      .rdata_b (rd_take)
   );

   lssd_cell_unit #(
      .CNT_W (CNT_W),
      .COL_W (SW)
   ) u_cell_unit (
      .skip_cnt (rd_skip),
      .take_cnt (rd_take),
      .col      (col_ff),
      .limit    (t_sat),
      .item     (item_a),
      .best     (best),
      .choose   (choose)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_is_last) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            if (last_col) begin
               state_in = (count_ff == '0) ? ST_HEAD_RD : ST_ROW;
            end
         end
         ST_ROW:     state_in = ST_FILL_RD;
         ST_FILL_RD: state_in = ST_FILL_WR;
         ST_FILL_WR: begin
            if (!last_col) begin
               state_in = ST_FILL_RD;
            end else if (row_ff == '0) begin
               state_in = ST_HEAD_RD;
            end else begin
               state_in = ST_ROW;
            end
         end
         ST_HEAD_RD: state_in = ST_HEAD;
         ST_HEAD: begin
            if (out_free) begin
               state_in = ((rd_skip == IMP) || (count_ff == '0)) ? ST_IDLE : ST_WALK_ITEM;
            end
         end
         ST_WALK_ITEM: state_in = ST_WALK_RD;
         ST_WALK_RD:   state_in = ST_WALK_CMP;
         ST_WALK_CMP: begin
            if (!choose || out_free) begin
               state_in = (row_next == count_ff) ? ST_IDLE : ST_WALK_ITEM;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath register updates.
   always_comb begin
      count_in   = count_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      k_in       = k_ff;
      len_in     = len_ff;
      tbl_we     = 1'b0;
      tbl_waddr  = {row_ff, col_ff};
      tbl_wdata  = best;
      emit       = 1'b0;
      emit_kind  = KIND_LENGTH;
      emit_value = '0;
      emit_end   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_we) begin
               count_in = count_ff + RW'(1);
            end
            if (accept && req_is_last) begin
               col_in = '0;
            end
         end
         ST_INIT: begin
            tbl_we    = 1'b1;
            tbl_waddr = {count_ff, col_ff};
            tbl_wdata = last_col ? '0 : IMP;
            if (last_col) begin
               col_in = '0;
               row_in = count_ff - RW'(1);
            end else begin
               col_in = col_ff + SW'(1);
            end
         end
         ST_FILL_WR: begin
            tbl_we = 1'b1;
            if (last_col) begin
               col_in = '0;
               row_in = row_ff - RW'(1);
            end else begin
               col_in = col_ff + SW'(1);
            end
         end
         ST_HEAD: begin
            if (out_free) begin
               emit = 1'b1;
               if (rd_skip == IMP) begin
                  emit_kind = KIND_NOT_FOUND;
                  emit_end  = 1'b1;
                  count_in  = '0;
               end else begin
                  emit_kind  = KIND_LENGTH;
                  emit_value = VALUE_W'(rd_skip);
                  emit_end   = (rd_skip == '0);
                  len_in     = rd_skip;
                  k_in       = CNT_W'(1);
                  row_in     = '0;
                  col_in     = '0;
               end
            end
         end
         ST_WALK_CMP: begin
            if (!choose || out_free) begin
               if (choose) begin
                  emit       = 1'b1;
                  emit_kind  = KIND_ELEMENT;
                  emit_value = item_a;
                  emit_end   = (k_ff == len_ff);
                  col_in     = sum_col[SW-1:0];
                  k_in       = k_ff + CNT_W'(1);
               end
               row_in = row_next;
               if (row_next == count_ff) begin
                  count_in = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_write_en) begin
            target_ff <= csr_write_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      k_ff   <= k_in;
      len_ff <= len_in;
      if (emit) begin
         rsp_kind_ff  <= emit_kind;
         rsp_value_ff <= emit_value;
         rsp_end_ff   <= emit_end;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_run_end = rsp_end_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= MAX_ITEMS)
      else $error("item count exceeds capacity");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result word loaded while the previous one is held");

   a_element_bound: assert property (@(posedge clock) disable iff (reset)
      (emit && (emit_kind == KIND_ELEMENT)) |-> (k_ff <= len_ff))
      else $error("more elements chosen than the subset length");

   a_not_found_ends: assert property (@(posedge clock) disable iff (reset)
      (emit && (emit_kind == KIND_NOT_FOUND)) |=> ((state_ff == ST_IDLE) && (count_ff == '0)))
      else $error("run did not end after a not-found word");

   a_fill_in_range: assert property (@(posedge clock) disable iff (reset)
      (tbl_we && (state_ff == ST_FILL_WR)) |-> ((col_ff <= t_sat) && (row_ff < count_ff)))
      else $error("table write outside the active region");

endmodule

// File: hw/rtl/lssd_ram.sv
// Generic RAM with one write port and two registered read ports.
module lssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr_a,
   output logic [WIDTH-1:0]  rdata_a,
   input  logic [ADDR_W-1:0] raddr_b,
   output logic [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_a_ff <= mem_ff[raddr_a];
      rd_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

// File: hw/rtl/lssd_cell_unit.sv
// Shared take-or-skip compare unit used for both the table fill and the walk.
module lssd_cell_unit #(
   parameter int CNT_W = 6,
   parameter int COL_W = 10
) (
   input  logic [CNT_W-1:0]             skip_cnt,
   input  logic [CNT_W-1:0]             take_cnt,
   input  logic [COL_W-1:0]             col,
   input  logic [COL_W-1:0]             limit,
   input  logic [lssd_pkg::VALUE_W-1:0] item,
   output logic [CNT_W-1:0]             best,
   output logic                         choose
);
   import lssd_pkg::*;

   localparam int SUM_W = ((COL_W > VALUE_W) ? COL_W : VALUE_W) + 1;
   localparam logic [CNT_W-1:0] IMP = '1;

   logic [SUM_W-1:0] reach;
   logic             take_ok;
   logic [CNT_W-1:0] take_inc;
   logic             skip_imp;

   assign reach    = SUM_W'(col) + SUM_W'(item);
   assign take_ok  = (reach <= SUM_W'(limit)) && (take_cnt != IMP);
   assign take_inc = take_cnt + CNT_W'(1);
   assign skip_imp = (skip_cnt == IMP);

   always_comb begin
      if (!take_ok) begin
         best = skip_cnt;
      end else if (skip_imp || (take_inc > skip_cnt)) begin
         best = take_inc;
      end else begin
         best = skip_cnt;
      end
   end

   // The walk prefers taking an item on a tie.
   assign choose = take_ok && (skip_imp || (take_inc >= skip_cnt));

endmodule

// File: dv/subset_answer_checker.sv
// Watches both channels and the target register, predicts the answer words and compares them.
module subset_answer_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [lssd_pkg::VALUE_W-1:0] req_item_value,
   input  logic                         req_is_last,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [lssd_pkg::KIND_W-1:0]  rsp_kind,
   input  logic [lssd_pkg::VALUE_W-1:0] rsp_value,
   input  logic                         rsp_run_end,
   input  logic                         csr_write_en,
   input  logic [lssd_pkg::VALUE_W-1:0] csr_write_data,
   output int                           fail_count,
   output int                           pending_words,
   output int                           words_checked,
   output int                           sets_solved
);
   import lssd_pkg::*;

   localparam int NO_PATH = 255;

   typedef struct packed {
      kind_type           kind;
      logic [VALUE_W-1:0] value;
      logic               run_end;
   } answer_word_type;

   answer_word_type    answer_q[$];
   logic [VALUE_W-1:0] set_values [0:MAX_ITEMS_DEF-1];
   logic [7:0]         most_items [0:MAX_ITEMS_DEF][0:MAX_TARGET_DEF];
   int                 set_len;
   int                 target;
   int                 fails;
   int                 checked;
   int                 solved;

   function automatic answer_word_type answer(kind_type k, int v, bit e);
      answer_word_type w;
      w.kind    = k;
      w.value   = VALUE_W'(v);
      w.run_end = e;
      return w;
   endfunction

   function automatic void add_answer(answer_word_type w);
      answer_q.insert(answer_q.size(), w);
   endfunction

   // Count of items from position i on when item i is taken at partial sum s.
   function automatic int take_count(int i, int s, int t);
      int a;
      a = set_values[i];
      if (s + a <= t && most_items[i+1][s+a] != NO_PATH) return most_items[i+1][s+a] + 1;
      return NO_PATH;
   endfunction

   task automatic solve_set();
      int t, n, take, skip, len, k, cs;
      t = (target > MAX_TARGET_DEF) ? MAX_TARGET_DEF : target;
      n = set_len;
      for (int s = 0; s <= t; s++) most_items[n][s] = (s == t) ? 8'd0 : 8'(NO_PATH);
      for (int i = n - 1; i >= 0; i--) begin
         for (int s = 0; s <= t; s++) begin
            take = take_count(i, s, t);
            skip = most_items[i+1][s];
            if (take == NO_PATH || (skip != NO_PATH && take <= skip)) most_items[i][s] = 8'(skip);
            else most_items[i][s] = 8'(take);
         end
      end
      set_len = 0;
      solved++;
      if (most_items[0][0] == NO_PATH) begin
         add_answer(answer(KIND_NOT_FOUND, 0, 1'b1));
      end else begin
         len = most_items[0][0];
         add_answer(answer(KIND_LENGTH, len, len == 0));
         k  = 1;
         cs = 0;
         // Walk forward from sum zero; a tie between take and skip goes to take.
         for (int i = 0; i < n; i++) begin
            take = take_count(i, cs, t);
            skip = most_items[i+1][cs];
            if (take != NO_PATH && (skip == NO_PATH || take >= skip)) begin
               cs += set_values[i];
               add_answer(answer(KIND_ELEMENT, set_values[i], k == len));
               k++;
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      answer_word_type exp_w;
      if (reset) begin
         set_len = 0;
         target  = 0;
         answer_q.delete();
      end else begin
         if (csr_write_en) target = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               $display("%0t: result word with nothing expected: kind %0d value %0d run_end %0d",
                        $time, rsp_kind, rsp_value, rsp_run_end);
               fails++;
            end else begin
               exp_w = answer_q.pop_front();
               checked++;
               if (rsp_kind !== exp_w.kind || rsp_value !== exp_w.value ||
                   rsp_run_end !== exp_w.run_end) begin
                  $display(
                     "%0t: expected kind %0d value %0d end %0d, got kind %0d value %0d end %0d",
                     $time, exp_w.kind, exp_w.value, exp_w.run_end,
                     rsp_kind, rsp_value, rsp_run_end);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            // A full store drops the word, but its last flag still starts the solve.
            if (set_len < MAX_ITEMS_DEF) begin
               set_values[set_len] = req_item_value;
               set_len++;
            end
            if (req_is_last) solve_set();
         end
      end
      fail_count    <= fails;
      pending_words <= answer_q.size();
      words_checked <= checked;
      sets_solved   <= solved;
   end

endmodule

// File: dv/longest_subset_sum_dp_tb.sv
// Top of the longest subset sum testbench: clock, reset, stimulus, receiver stalls and verdict.
module longest_subset_sum_dp_tb;
   import lssd_pkg::*;

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic [VALUE_W-1:0] req_item_value = '0;
   logic               req_is_last    = 1'b0;
   logic               rsp_stall      = 1'b0;
   logic               csr_write_en   = 1'b0;
   logic [VALUE_W-1:0] csr_write_data = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic [KIND_W-1:0]  rsp_kind;
   logic [VALUE_W-1:0] rsp_value;
   logic               rsp_run_end;

   int fail_count;
   int pending_words;
   int words_checked;
   int sets_solved;
   int words_sent      = 0;
   int burst_left      = 1;
   int targets_written = 0;
   bit hold_done       = 1'b0;

   longest_subset_sum_dp uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item_value (req_item_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_run_end    (rsp_run_end),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   subset_answer_checker answer_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_item_value (req_item_value),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_value      (rsp_value),
      .rsp_run_end    (rsp_run_end),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending_words  (pending_words),
      .words_checked  (words_checked),
      .sets_solved    (sets_solved)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   // Offers one word and holds it until accepted; bursts end in a random gap.
   task automatic send_word(input int v, input bit last);
      req_valid      <= 1'b1;
      req_item_value <= VALUE_W'(v);
      req_is_last    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
      end
   endtask

   task automatic send_set(input int vals[$]);
      foreach (vals[i]) send_word(vals[i], i == vals.size() - 1);
   endtask

   task automatic write_target(input int v);
      csr_write_en   <= 1'b1;
      csr_write_data <= VALUE_W'(v);
      @(posedge clock);
      csr_write_en <= 1'b0;
      targets_written++;
   endtask

   // Waits until every expected word has arrived and the block has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0 || req_stall) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : receiver
      int mode;
      wait (!reset);
      @(posedge clock);
      forever begin
         // One long hold-off while a word waits, so the block backs up and stalls its input.
         if (!hold_done && words_checked >= 30 && req_valid && req_stall) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            hold_done = 1'b1;
         end
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(10, 80)) begin
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int sv[$];
      int t, n, r, v, sum;
      bit overflow_done;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      write_target(0);
      sv = '{0};
      send_set(sv);
      sv = '{7};
      send_set(sv);
      drain();
      write_target(1023);
      sv = '{1023};
      send_set(sv);
      sv = '{512, 511, 0};
      send_set(sv);
      sv = '{1000, 5};
      send_set(sv);
      drain();
      write_target(10);
      sv = '{3, 7, 5, 5, 2, 8, 0, 10};
      send_set(sv);
      sv = '{1, 2};
      send_set(sv);
      sv = '{5, 5, 10, 0};
      send_set(sv);
      drain();

      overflow_done = 1'b0;
      while (words_sent < 210) begin
         r = $urandom_range(0, 9);
         case (r)
            0: t = 0;
            1: t = 1023;
            2: t = $urandom_range(100, 1023);
            default: t = $urandom_range(1, 40);
         endcase
         write_target(t);
         repeat ($urandom_range(2, 5)) begin
            // Large targets make the fill slow, so those sets stay short.
            if (t > 100) begin
               n = $urandom_range(1, 4);
            end else if (!overflow_done || $urandom_range(0, 11) == 0) begin
               n = $urandom_range(33, 36);
               overflow_done = 1'b1;
            end else begin
               n = $urandom_range(1, 8);
            end
            sv.delete();
            sum = 0;
            for (int i = 0; i < n; i++) begin
               r = $urandom_range(0, 9);
               if (i == n - 1 && r < 4 && sum <= t) v = t - sum;
               else if (r < 2) v = $urandom_range(0, 1023);
               else if (r == 2) v = 0;
               else v = $urandom_range(0, (t > 100) ? t / n : t + 1);
               if (i < MAX_ITEMS_DEF) sum += v;
               sv.insert(sv.size(), v);
            end
            send_set(sv);
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d input words in %0d solved sets, %0d result words checked",
               words_sent, sets_solved, words_checked);
      $display("%0d target settings including 0 and 1023, one oversized set, one long hold-off",
               targets_written);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
